### hw/rtl/assert_macros.svh
// Assertion helpers shared by the interpolation block.
// Each check samples on clk_i and stays off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define BTIN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Implication: when ante holds, cons holds on the same edge.
`define BTIN_ASSERT_IMP(lbl, ante, cons) \
  `BTIN_ASSERT(lbl, (ante) |-> (cons))

`endif

### hw/rtl/btin_pkg.sv
package btin_pkg;

  // Fixed field widths of the item formats
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned ENTRY_W  = 6;
  localparam int unsigned BINS_W   = 7;
  localparam int unsigned BPU_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Widest cell index and fraction any parameter setting needs
  localparam int unsigned CELL_W   = 10;
  localparam int unsigned FRACF_W  = 25;
  localparam int unsigned EBINS_W  = 11;

  // Parameter defaults
  localparam int unsigned DEF_MAX_X_POINTS = 64;
  localparam int unsigned DEF_MAX_Y_POINTS = 64;
  localparam int unsigned DEF_VALUE_WIDTH  = 32;
  localparam int unsigned DEF_FRAC_BITS    = 16;
  localparam int unsigned QUEUE_DEPTH      = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_BPU    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_BPU    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_BINS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_BINS   = 3'd5;

  // Action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [COORD_W-1:0]  x_coord;
    logic signed [COORD_W-1:0]  y_coord;
    logic [ENTRY_W-1:0]         entry_x_index;
    logic [ENTRY_W-1:0]         entry_y_index;
    logic signed [SAMPLE_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] interpolated;
    logic                       out_of_range;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_origin;
    logic signed [COORD_W-1:0] y_origin;
    logic [BPU_W-1:0]          x_bpu;
    logic [BPU_W-1:0]          y_bpu;
    logic [BINS_W-1:0]         x_bins;
    logic [BINS_W-1:0]         y_bins;
  } cfg_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic                       is_load;
    logic [CELL_W-1:0]          cx;
    logic [CELL_W-1:0]          cy;
    logic [FRACF_W-1:0]         fx;
    logic [FRACF_W-1:0]         fy;
    logic                       oor;
    logic [ENTRY_W-1:0]         ex;
    logic [ENTRY_W-1:0]         ey;
    logic signed [SAMPLE_W-1:0] value;
  } qent_t;

endpackage

### hw/rtl/bilinear_table_interpolation.sv
// Bilinear lookup over a regular grid of signed Q16.16 samples.
// Input channel (in_valid_i/in_ready_o, in_item_i): action selects a load,
// which writes one grid entry and gives no result, or an evaluate, which
// gives one result item (interpolated value, out_of_range flag).
// Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
// sets origins, reciprocal bin widths and point counts; it is always ready
// and should be written only while no item is in flight.
// Throughput: one item per cycle while the receiver keeps out_ready_i high.
// The front end registers the offset, then the 32x32 scaled product, and
// clamps into a four-entry queue; the back end reads four parity banks
// and blends through three registered stages.
// A stalled receiver holds the result register; the back end stops, the
// queue fills, and then in_ready_o drops, so nothing is lost.
// Reset clears control and configuration (bin width 1.0, 64 points each
// axis, origin 0). Grid contents are undefined until loaded; no clearing
// pass runs, so the block is ready straight out of reset.
module bilinear_table_interpolation #(
  parameter int unsigned MAX_X_POINTS = btin_pkg::DEF_MAX_X_POINTS,
  parameter int unsigned MAX_Y_POINTS = btin_pkg::DEF_MAX_Y_POINTS,
  parameter int unsigned VALUE_WIDTH  = btin_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned FRAC_BITS    = btin_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  btin_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output btin_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [btin_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);

  btin_pkg::cfg_t  cfg_q;
  btin_pkg::qent_t push_item, pop_item;
  logic push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin <= '0;
      cfg_q.y_origin <= '0;
      cfg_q.x_bpu    <= 32'd65536;
      cfg_q.y_bpu    <= 32'd65536;
      cfg_q.x_bins   <= 7'd64;
      cfg_q.y_bins   <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        btin_pkg::REG_X_ORIGIN: cfg_q.x_origin <= cfg_data_i;
        btin_pkg::REG_Y_ORIGIN: cfg_q.y_origin <= cfg_data_i;
        btin_pkg::REG_X_BPU:    cfg_q.x_bpu    <= cfg_data_i;
        btin_pkg::REG_Y_BPU:    cfg_q.y_bpu    <= cfg_data_i;
        btin_pkg::REG_X_BINS:   cfg_q.x_bins   <= cfg_data_i[btin_pkg::BINS_W-1:0];
        btin_pkg::REG_Y_BINS:   cfg_q.y_bins   <= cfg_data_i[btin_pkg::BINS_W-1:0];
        default: ;
      endcase
    end
  end

  btin_front #(
    .MAX_X_POINTS(MAX_X_POINTS),
    .MAX_Y_POINTS(MAX_Y_POINTS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg_q),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_item_o (push_item)
  );

  btin_queue #(
    .DEPTH(btin_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item)
  );

  btin_back #(
    .MAX_X_POINTS(MAX_X_POINTS),
    .MAX_Y_POINTS(MAX_Y_POINTS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_item_i (pop_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

### hw/rtl/btin_front.sv
`include "assert_macros.svh"

module btin_front #(
  parameter int unsigned MAX_X_POINTS = btin_pkg::DEF_MAX_X_POINTS,
  parameter int unsigned MAX_Y_POINTS = btin_pkg::DEF_MAX_Y_POINTS,
  parameter int unsigned FRAC_BITS    = btin_pkg::DEF_FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  btin_pkg::in_item_t in_item_i,
  input  btin_pkg::cfg_t    cfg_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output btin_pkg::qent_t   push_item_o
);

  localparam int unsigned EW = btin_pkg::EBINS_W;
  localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

  logic en;
  logic v1_q, v2_q;
  logic load1_q, load2_q;
  logic [btin_pkg::ENTRY_W-1:0] ex1_q, ey1_q, ex2_q, ey2_q;
  logic signed [btin_pkg::SAMPLE_W-1:0] val1_q, val2_q;
  logic        neg1_q [2];
  logic [31:0] mag1_q [2];
  logic [31:0] bpu1_q [2];
  logic [EW-1:0] bins1_q [2];
  logic        neg2_q [2];
  logic        bpuz2_q [2];
  logic [63:0] prod2_q [2];
  logic [EW-1:0] bins2_q [2];

  logic signed [32:0] diff [2];
  logic [EW-1:0] bins_eff [2];
  logic [btin_pkg::CELL_W-1:0]  cell_idx [2];
  logic [btin_pkg::FRACF_W-1:0] frac [2];
  logic oor_ax [2];

  assign en         = !v2_q || push_ready_i;
  assign in_ready_o = en;

  // Offset from origin and effective point counts
  always_comb begin
    diff[0] = 33'(in_item_i.x_coord) - 33'(cfg_i.x_origin);
    diff[1] = 33'(in_item_i.y_coord) - 33'(cfg_i.y_origin);
    bins_eff[0] = (cfg_i.x_bins < 7'd2) ? EW'(2) :
                  (32'(cfg_i.x_bins) > MAX_X_POINTS) ? EW'(MAX_X_POINTS) : EW'(cfg_i.x_bins);
    bins_eff[1] = (cfg_i.y_bins < 7'd2) ? EW'(2) :
                  (32'(cfg_i.y_bins) > MAX_Y_POINTS) ? EW'(MAX_Y_POINTS) : EW'(cfg_i.y_bins);
  end

  // Stage 1: capture offset; stage 2: scale by reciprocal bin width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      load1_q <= (in_item_i.action == btin_pkg::ACT_LOAD);
      ex1_q   <= in_item_i.entry_x_index;
      ey1_q   <= in_item_i.entry_y_index;
      val1_q  <= in_item_i.entry_value;
      load2_q <= load1_q;
      ex2_q   <= ex1_q;
      ey2_q   <= ey1_q;
      val2_q  <= val1_q;
      for (int a = 0; a < 2; a++) begin
        neg1_q[a]  <= diff[a][32];
        mag1_q[a]  <= diff[a][31:0];
        bins1_q[a] <= bins_eff[a];
        neg2_q[a]  <= neg1_q[a];
        bpuz2_q[a] <= (bpu1_q[a] == 32'd0);
        prod2_q[a] <= 64'(mag1_q[a]) * 64'(bpu1_q[a]);
        bins2_q[a] <= bins1_q[a];
      end
      bpu1_q[0] <= cfg_i.x_bpu;
      bpu1_q[1] <= cfg_i.y_bpu;
    end
  end

  // Clamp position and split into cell and fraction
  always_comb begin
    logic [63:0] pos;
    logic [63:0] limit;
    logic [63:0] c;
    for (int a = 0; a < 2; a++) begin
      pos   = prod2_q[a] >> FRAC_BITS;
      limit = 64'(bins2_q[a] - EW'(1)) << FRAC_BITS;
      oor_ax[a] = 1'b0;
      if (neg2_q[a]) begin
        pos = 64'd0;
        oor_ax[a] = !bpuz2_q[a];
      end else if (pos > limit) begin
        pos = limit;
        oor_ax[a] = 1'b1;
      end
      c = pos >> FRAC_BITS;
      if (c >= 64'(bins2_q[a] - EW'(1))) begin
        cell_idx[a] = btin_pkg::CELL_W'(bins2_q[a] - EW'(2));
        frac[a] = btin_pkg::FRACF_W'(ONE);
      end else begin
        cell_idx[a] = btin_pkg::CELL_W'(c);
        frac[a] = btin_pkg::FRACF_W'(pos & (ONE - 64'd1));
      end
    end
  end

  always_comb begin
    push_valid_o       = v2_q;
    push_item_o.is_load = load2_q;
    push_item_o.cx     = cell_idx[0];
    push_item_o.cy     = cell_idx[1];
    push_item_o.fx     = frac[0];
    push_item_o.fy     = frac[1];
    push_item_o.oor    = oor_ax[0] || oor_ax[1];
    push_item_o.ex     = ex2_q;
    push_item_o.ey     = ey2_q;
    push_item_o.value  = val2_q;
  end

  `BTIN_ASSERT_IMP(a_frac_le_one, push_valid_o && !load2_q,
                   (push_item_o.fx <= btin_pkg::FRACF_W'(ONE)) &&
                   (push_item_o.fy <= btin_pkg::FRACF_W'(ONE)))
  `BTIN_ASSERT_IMP(a_cell_in_grid, push_valid_o && !load2_q,
                   (32'(push_item_o.cx) + 32'd2 <= 32'(bins2_q[0])) &&
                   (32'(push_item_o.cy) + 32'd2 <= 32'(bins2_q[1])))

endmodule

### hw/rtl/btin_queue.sv
`include "assert_macros.svh"

module btin_queue #(
  parameter int unsigned DEPTH = btin_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  btin_pkg::qent_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output btin_pkg::qent_t pop_item_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  btin_pkg::qent_t mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] count_q;
  logic push, pop;

  assign push_ready_o = (count_q < CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_item_o = mem_q[rd_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push) wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
      if (pop)  rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
      if (push && !pop)      count_q <= count_q + CW'(1);
      else if (pop && !push) count_q <= count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

  `BTIN_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
  `BTIN_ASSERT_IMP(a_ptr_gap, count_q == '0 || 32'(count_q) == DEPTH,
                   wr_q == rd_q)

endmodule

### hw/rtl/btin_back.sv
`include "assert_macros.svh"

module btin_back #(
  parameter int unsigned MAX_X_POINTS = btin_pkg::DEF_MAX_X_POINTS,
  parameter int unsigned MAX_Y_POINTS = btin_pkg::DEF_MAX_Y_POINTS,
  parameter int unsigned VALUE_WIDTH  = btin_pkg::DEF_VALUE_WIDTH,
  parameter int unsigned FRAC_BITS    = btin_pkg::DEF_FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  btin_pkg::qent_t     pop_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output btin_pkg::out_item_t out_item_o
);

  localparam int unsigned SW    = btin_pkg::SAMPLE_W;
  localparam int unsigned FW    = FRAC_BITS + 1;
  localparam int unsigned WW    = 2 * FRAC_BITS + 1;
  localparam int unsigned PRW   = SW + WW + 1;
  localparam int unsigned ACCW  = PRW + 2;
  localparam int unsigned RW    = ACCW - 2 * FRAC_BITS;
  localparam int unsigned SATW  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned XH    = (MAX_X_POINTS + 1) / 2;
  localparam int unsigned YH    = (MAX_Y_POINTS + 1) / 2;
  localparam int unsigned BDEPTH = XH * YH;
  localparam int unsigned BAW   = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'(1) << (SATW - 1)) - 64'd1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  logic en, fire, eval_fire, wr_en;
  logic [1:0] wr_bank;
  logic [BAW-1:0] wr_addr;
  logic [BAW-1:0] rd_addr [4];
  logic [FW-1:0] fx, fy, gx, gy;

  logic v1_q, v2_q, out_valid_q;
  logic oor1_q, oor2_q;
  logic px_q, py_q;
  logic [WW-1:0] w1_q [4];
  logic signed [SW-1:0] rd_q [4];
  logic signed [PRW-1:0] prod2_q [4];
  btin_pkg::out_item_t out_q;

  logic signed [ACCW-1:0] acc;
  logic signed [RW-1:0] r;
  logic signed [SW-1:0] sample [4];

  assign en          = !out_valid_q || out_ready_i;
  assign pop_ready_o = en;
  assign fire        = pop_valid_i && en;
  assign eval_fire   = fire && !pop_item_i.is_load;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Weights from the fractions
  assign fx = FW'(pop_item_i.fx);
  assign fy = FW'(pop_item_i.fy);
  assign gx = ONE - fx;
  assign gy = ONE - fy;

  // Bank addressing: banks split the grid by index parity
  always_comb begin
    int xi, yi;
    int ex, ey;
    ex = int'(pop_item_i.ex);
    ey = int'(pop_item_i.ey);
    wr_en   = fire && pop_item_i.is_load &&
              (32'(ex) < MAX_X_POINTS) && (32'(ey) < MAX_Y_POINTS);
    wr_bank = {pop_item_i.ex[0], pop_item_i.ey[0]};
    wr_addr = BAW'((ex >> 1) * YH + (ey >> 1));
    for (int b = 0; b < 4; b++) begin
      xi = int'(pop_item_i.cx) + int'(pop_item_i.cx[0] ^ b[1]);
      yi = int'(pop_item_i.cy) + int'(pop_item_i.cy[0] ^ b[0]);
      rd_addr[b] = BAW'((xi >> 1) * YH + (yi >> 1));
    end
  end

  // Four sample banks, one read port each
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic signed [SW-1:0] mem [BDEPTH];
    always_ff @(posedge clk_i) begin
      if (wr_en && wr_bank == 2'(b)) mem[wr_addr] <= pop_item_i.value;
      if (en) rd_q[b] <= mem[rd_addr[b]];
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= eval_fire;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // Route bank data to corners
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sample[c] = rd_q[{px_q ^ c[1], py_q ^ c[0]}];
    end
  end

  // Blend, round half up and saturate
  always_comb begin
    acc = ACCW'(prod2_q[0]) + ACCW'(prod2_q[1]) + ACCW'(prod2_q[2]) + ACCW'(prod2_q[3])
        + (ACCW'(1) <<< (2 * FRAC_BITS - 1));
    r = RW'(acc >>> (2 * FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oor1_q <= pop_item_i.oor;
      px_q   <= pop_item_i.cx[0];
      py_q   <= pop_item_i.cy[0];
      w1_q[0] <= WW'(gx * gy);
      w1_q[1] <= WW'(gx * fy);
      w1_q[2] <= WW'(fx * gy);
      w1_q[3] <= WW'(fx * fy);
      oor2_q <= oor1_q;
      for (int c = 0; c < 4; c++) begin
        prod2_q[c] <= PRW'(sample[c]) * $signed({1'b0, w1_q[c]});
      end
      out_q.out_of_range <= oor2_q;
      if (r > SAT_HI)      out_q.interpolated <= SW'(SAT_HI);
      else if (r < SAT_LO) out_q.interpolated <= SW'(SAT_LO);
      else                 out_q.interpolated <= SW'(r);
    end
  end

  `BTIN_ASSERT_IMP(a_result_follows, $past(en && v2_q), out_valid_q)
  `BTIN_ASSERT_IMP(a_no_load_result, $past(en && fire && pop_item_i.is_load), !v1_q)

endmodule
